### src/blru_pkg.sv
// ----------------------------------------------------------------------------
// blru_pkg
// Shared types and constants of the LRU buffer cache tag store.
// ----------------------------------------------------------------------------
`default_nettype none

package blru_pkg;

  localparam int NUM_BUFFERS = 32;
  localparam int IDX_W       = (NUM_BUFFERS > 1) ? $clog2(NUM_BUFFERS) : 1;

  localparam logic [7:0] COUNT_MAX = 8'hFF;

  typedef enum logic [2:0] {
    ACT_GET        = 3'd0,
    ACT_RELEASE    = 3'd1,
    ACT_PIN        = 3'd2,
    ACT_UNPIN      = 3'd3,
    ACT_MARK_VALID = 3'd4
  } action_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_FREE   = 2'd1,
    ST_COUNT_ERR = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_RD,
    S_FIN
  } state_e;

  typedef struct packed {
    logic [2:0]  action;
    logic [7:0]  device;
    logic [31:0] block_number;
    logic [4:0]  slot;
    logic [31:0] now;
  } item_t;

  typedef struct packed {
    logic [4:0] entry;
    logic       hit;
    logic       needs_read;
    status_e    status;
  } res_t;

  typedef struct packed {
    logic [7:0]  device;
    logic [31:0] block;
    logic [7:0]  count;
    logic [31:0] stamp;
    logic        valid;
  } rec_t;

  localparam int REC_W = $bits(rec_t);

  typedef struct packed {
    logic             ren;
    logic [IDX_W-1:0] raddr;
    logic             wen;
    logic [IDX_W-1:0] waddr;
    rec_t             wrec;
  } mem_req_t;

endpackage

`default_nettype wire

### src/blru_ram.sv
// ----------------------------------------------------------------------------
// blru_ram
// Single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module blru_ram #(
  parameter int DEPTH  = 32,
  parameter int WIDTH  = 8,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### src/blru_store.sv
// ----------------------------------------------------------------------------
// blru_store
// Entry record memory with per-entry written bits; unwritten entries read zero.
// ----------------------------------------------------------------------------
`default_nettype none

module blru_store (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  blru_pkg::mem_req_t  req_i,
  output blru_pkg::rec_t      rec_o
);

  import blru_pkg::*;

  logic [NUM_BUFFERS-1:0] seen_q;
  logic                   seen_rd_q;
  logic [REC_W-1:0]       rdata;

  blru_ram #(
    .DEPTH (NUM_BUFFERS),
    .WIDTH (REC_W),
    .ADDR_W(IDX_W)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (req_i.wen),
    .waddr_i(req_i.waddr),
    .wdata_i(req_i.wrec),
    .re_i   (req_i.ren),
    .raddr_i(req_i.raddr),
    .rdata_o(rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q    <= '0;
      seen_rd_q <= 1'b0;
    end else begin
      if (req_i.ren) begin
        seen_rd_q <= seen_q[req_i.raddr];
      end
      if (req_i.wen) begin
        seen_q[req_i.waddr] <= 1'b1;
      end
    end
  end

  assign rec_o = seen_rd_q ? rec_t'(rdata) : '0;

endmodule

`default_nettype wire

### src/blru_ctrl.sv
// ----------------------------------------------------------------------------
// blru_ctrl
// Sequencer: scans entries for tag hit and LRU victim, read-modify-writes.
// ----------------------------------------------------------------------------
`default_nettype none

module blru_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  blru_pkg::item_t    item_i,
  input  logic               out_free_i,
  output logic               out_load_o,
  output blru_pkg::res_t     res_o,
  output blru_pkg::mem_req_t req_o,
  input  blru_pkg::rec_t     rec_i
);

  import blru_pkg::*;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_BUFFERS - 1);

  state_e           state_q, state_d;
  item_t            item_q, item_d;
  logic [IDX_W-1:0] scan_q, scan_d;
  logic             found_q, found_d;
  logic [IDX_W-1:0] best_idx_q, best_idx_d;
  logic [31:0]      best_stamp_q, best_stamp_d;
  logic             wen_q, wen_d;
  logic [IDX_W-1:0] waddr_q, waddr_d;
  rec_t             wrec_q, wrec_d;
  res_t             res_q, res_d;

  logic             accept;
  logic             in_range;
  logic             act_known;
  logic             match;
  logic             cand;
  logic [IDX_W-1:0] slot_idx;
  logic [IDX_W-1:0] item_slot_idx;

  assign accept        = in_valid_i && in_ready_o;
  assign slot_idx      = IDX_W'(item_i.slot);
  assign item_slot_idx = IDX_W'(item_q.slot);
  assign in_range      = 32'(item_i.slot) < NUM_BUFFERS;
  assign act_known     = item_i.action inside {ACT_RELEASE, ACT_PIN, ACT_UNPIN, ACT_MARK_VALID};
  assign match         = (rec_i.device == item_q.device) &&
                         (rec_i.block == item_q.block_number);
  assign cand          = (rec_i.count == 8'd0) && (!found_q || (rec_i.stamp < best_stamp_q));

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (item_i.action == ACT_GET) begin
            state_d = S_SCAN;
          end else if (act_known && in_range) begin
            state_d = S_RD;
          end else begin
            state_d = S_FIN;
          end
        end
      end
      S_SCAN: begin
        if (match || (scan_q == LAST_IDX)) begin
          state_d = S_FIN;
        end
      end
      S_RD: state_d = S_FIN;
      S_FIN: begin
        if (out_free_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    item_d       = item_q;
    scan_d       = scan_q;
    found_d      = found_q;
    best_idx_d   = best_idx_q;
    best_stamp_d = best_stamp_q;
    wen_d        = wen_q;
    waddr_d      = waddr_q;
    wrec_d       = wrec_q;
    res_d        = res_q;
    in_ready_o   = 1'b0;
    out_load_o   = 1'b0;
    req_o        = '0;
    req_o.waddr  = waddr_q;
    req_o.wrec   = wrec_q;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (accept) begin
          item_d     = item_i;
          wen_d      = 1'b0;
          scan_d     = '0;
          found_d    = 1'b0;
          res_d      = '0;
          res_d.entry = item_i.slot;
          if (item_i.action == ACT_GET) begin
            req_o.ren   = 1'b1;
            req_o.raddr = '0;
          end else if (act_known && in_range) begin
            req_o.ren   = 1'b1;
            req_o.raddr = slot_idx;
          end else if (act_known) begin
            res_d.status = ST_COUNT_ERR;
          end
        end
      end
      S_SCAN: begin
        waddr_d = scan_q;
        if (match) begin
          res_d.entry      = 5'(scan_q);
          res_d.hit        = 1'b1;
          res_d.needs_read = !rec_i.valid;
          wrec_d           = rec_i;
          wrec_d.count     = rec_i.count + 8'd1;
          if (rec_i.count == COUNT_MAX) begin
            res_d.status = ST_COUNT_ERR;
            wen_d        = 1'b0;
          end else begin
            res_d.status = ST_OK;
            wen_d        = 1'b1;
          end
        end else begin
          if (cand) begin
            found_d      = 1'b1;
            best_idx_d   = scan_q;
            best_stamp_d = rec_i.stamp;
          end
          if (scan_q == LAST_IDX) begin
            wrec_d.device = item_q.device;
            wrec_d.block  = item_q.block_number;
            wrec_d.count  = 8'd1;
            wrec_d.stamp  = best_stamp_d;
            wrec_d.valid  = 1'b0;
            waddr_d       = best_idx_d;
            res_d.hit     = 1'b0;
            if (found_d) begin
              wen_d            = 1'b1;
              res_d.entry      = 5'(best_idx_d);
              res_d.needs_read = 1'b1;
              res_d.status     = ST_OK;
            end else begin
              wen_d            = 1'b0;
              res_d.entry      = '0;
              res_d.needs_read = 1'b0;
              res_d.status     = ST_NO_FREE;
            end
          end else begin
            scan_d      = scan_q + 1'b1;
            req_o.ren   = 1'b1;
            req_o.raddr = scan_q + 1'b1;
          end
        end
      end
      S_RD: begin
        waddr_d      = item_slot_idx;
        wrec_d       = rec_i;
        wen_d        = 1'b1;
        res_d.status = ST_OK;
        case (item_q.action)
          ACT_RELEASE: begin
            wrec_d.count = rec_i.count - 8'd1;
            if (rec_i.count == 8'd0) begin
              wen_d        = 1'b0;
              res_d.status = ST_COUNT_ERR;
            end else if (rec_i.count == 8'd1) begin
              wrec_d.stamp = item_q.now;
            end
          end
          ACT_PIN: begin
            wrec_d.count = rec_i.count + 8'd1;
            if (rec_i.count == COUNT_MAX) begin
              wen_d        = 1'b0;
              res_d.status = ST_COUNT_ERR;
            end
          end
          ACT_UNPIN: begin
            wrec_d.count = rec_i.count - 8'd1;
            if (rec_i.count == 8'd0) begin
              wen_d        = 1'b0;
              res_d.status = ST_COUNT_ERR;
            end
          end
          default: wrec_d.valid = 1'b1;
        endcase
      end
      S_FIN: begin
        out_load_o = out_free_i;
        req_o.wen  = wen_q && out_free_i;
      end
      default: ;
    endcase
  end

  assign res_o = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      found_q <= 1'b0;
      wen_q   <= 1'b0;
      scan_q  <= '0;
    end else begin
      state_q <= state_d;
      found_q <= found_d;
      wen_q   <= wen_d;
      scan_q  <= scan_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q       <= item_d;
    best_idx_q   <= best_idx_d;
    best_stamp_q <= best_stamp_d;
    waddr_q      <= waddr_d;
    wrec_q       <= wrec_d;
    res_q        <= res_d;
  end

endmodule

`default_nettype wire

### src/block_buffer_cache_lru.sv
// ----------------------------------------------------------------------------
// block_buffer_cache_lru
// Fully associative buffer cache tag store with timestamp LRU replacement.
//
// The slave stream carries one command per beat: tuser holds the action
// (get, release, pin, unpin, mark_valid), tdata the device, block number,
// slot and current time. The master stream returns one result beat per
// command: entry, hit, needs_read and status.
//
// One command is worked on at a time. A get reads the entry records from the
// tag memory one per cycle, stopping at the first tag match, while tracking
// the unreferenced entry with the oldest release stamp. Other actions do one
// read-modify-write of the named entry.
//
// Reset clears all entries at once through per-entry written bits. A result
// waits in the output register while the receiver stalls; the next command
// is accepted meanwhile and finishes as soon as that register frees up.
// ----------------------------------------------------------------------------
`default_nettype none

module block_buffer_cache_lru (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [79:0] s_axis_tdata,  // device, block_number, slot, now, zero pad
  input  logic [2:0]  s_axis_tuser,  // action
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata   // entry, hit, needs_read, status, zero pad
);

  import blru_pkg::*;

  item_t    item;
  res_t     res;
  res_t     out_q;
  logic     out_valid_q;
  logic     out_free;
  logic     out_load;
  mem_req_t req;
  rec_t     rec;

  assign item.action       = s_axis_tuser;
  assign item.device       = s_axis_tdata[7:0];
  assign item.block_number = s_axis_tdata[39:8];
  assign item.slot         = s_axis_tdata[44:40];
  assign item.now          = s_axis_tdata[76:45];

  assign out_free = !out_valid_q || m_axis_tready;

  blru_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid),
    .in_ready_o(s_axis_tready),
    .item_i    (item),
    .out_free_i(out_free),
    .out_load_o(out_load),
    .res_o     (res),
    .req_o     (req),
    .rec_i     (rec)
  );

  blru_store u_store (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req),
    .rec_o (rec)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'd0, out_q.status, out_q.needs_read, out_q.hit, out_q.entry};

endmodule

`default_nettype wire
